/* hw/rtl/dmpc_pkg.sv */
// shared types and constants for the direct mapped page cache controller
// no dependencies; imported by the interfaces and every module
`default_nettype none

package dmpc_pkg;

    // address split
    localparam int ADDR_W   = 22;
    localparam int OFFSET_W = 12;
    localparam int PAGE_W   = 10;

    // frame store
    localparam int FRAMES  = 64;
    localparam int FRAME_W = 6;

    // frames_in_use register
    localparam int CFG_W = 7;
    localparam logic [CFG_W-1:0] CFG_MIN = CFG_W'(1);
    localparam logic [CFG_W-1:0] CFG_MAX = CFG_W'(FRAMES);
    localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(FRAMES);

    // modulo unit: bits of the page retired per cycle
    localparam int MOD_STEPS  = 5;
    localparam int MOD_CYCLES = PAGE_W / MOD_STEPS;
    localparam int MOD_CNT_W  = $clog2(MOD_CYCLES + 1);

    // result kinds
    typedef enum logic [1:0] {
        KIND_ACCESS = 2'd0,
        KIND_WB     = 2'd1,
        KIND_FETCH  = 2'd2
    } kind_t;

    // controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MOD,
        ST_LOOKUP,
        ST_WB,
        ST_FETCH,
        ST_ACC
    } state_t;

    // one frame entry
    typedef struct packed {
        logic              dirty;
        logic [PAGE_W-1:0] tag;
    } frame_entry_t;

endpackage

`default_nettype wire

/* hw/rtl/dmpc_if.sv */
// valid/ready channel interfaces for requests, results and configuration
// depends on dmpc_pkg
`default_nettype none

interface dmpc_req_if;
    import dmpc_pkg::*;
    logic              valid;
    logic              ready;
    logic [ADDR_W-1:0] byte_address;
    logic              is_write;

    modport source (output valid, output byte_address, output is_write, input ready);
    modport sink   (input valid, input byte_address, input is_write, output ready);
endinterface

interface dmpc_rsp_if;
    import dmpc_pkg::*;
    logic                valid;
    logic                ready;
    logic [1:0]          kind;
    logic [PAGE_W-1:0]   page_number;
    logic [FRAME_W-1:0]  frame_index;
    logic [OFFSET_W-1:0] page_offset;
    logic                last_result;

    modport source (output valid, output kind, output page_number, output frame_index,
                    output page_offset, output last_result, input ready);
    modport sink   (input valid, input kind, input page_number, input frame_index,
                    input page_offset, input last_result, output ready);
endinterface

interface dmpc_cfg_if;
    import dmpc_pkg::*;
    logic             valid;
    logic             ready;
    logic [CFG_W-1:0] frames_in_use;

    modport source (output valid, output frames_in_use, input ready);
    modport sink   (input valid, input frames_in_use, output ready);
endinterface

`default_nettype wire

/* hw/rtl/dmpc_mod_unit.sv */
// iterative page modulo frame count, restoring remainder a few bits per cycle
// depends on dmpc_pkg
`default_nettype none

module dmpc_mod_unit (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         start,
    input  wire logic [dmpc_pkg::PAGE_W-1:0]  dividend,
    input  wire logic [dmpc_pkg::CFG_W-1:0]   divisor,
    output logic                              done,
    output logic [dmpc_pkg::FRAME_W-1:0]      remainder
);
    import dmpc_pkg::*;

    logic [CFG_W-1:0]     rem_reg, rem_next;
    logic [PAGE_W-1:0]    dvd_reg, dvd_next;
    logic [CFG_W-1:0]     div_reg;
    logic [MOD_CNT_W-1:0] cnt_reg;
    logic                 done_reg;

    // one cycle worth of restoring steps
    always_comb
    begin
        logic [CFG_W:0]    r;
        logic [PAGE_W-1:0] d;
        r = {1'b0, rem_reg};
        d = dvd_reg;
        for (int i = 0; i < MOD_STEPS; i++)
        begin
            r = {r[CFG_W-1:0], d[PAGE_W-1]};
            d = {d[PAGE_W-2:0], 1'b0};
            if (r >= {1'b0, div_reg})
            begin
                r = r - {1'b0, div_reg};
            end
        end
        rem_next = r[CFG_W-1:0];
        dvd_next = d;
    end

    // control counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else if (start)
        begin
            cnt_reg  <= MOD_CNT_W'(MOD_CYCLES);
            done_reg <= 1'b0;
        end
        else if (cnt_reg != '0)
        begin
            cnt_reg  <= cnt_reg - MOD_CNT_W'(1);
            done_reg <= (cnt_reg == MOD_CNT_W'(1));
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            dvd_reg <= dividend;
            div_reg <= divisor;
        end
        else if (cnt_reg != '0)
        begin
            rem_reg <= rem_next;
            dvd_reg <= dvd_next;
        end
    end

    assign done      = done_reg;
    assign remainder = rem_reg[FRAME_W-1:0];

endmodule

`default_nettype wire

/* hw/rtl/dmpc_frame_mem.sv */
// frame tag and dirty store, one read and one write port, registered read
// depends on dmpc_pkg; entries never written read as their reset contents
`default_nettype none

module dmpc_frame_mem (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          rd_en,
    input  wire logic [dmpc_pkg::FRAME_W-1:0]  rd_addr,
    output dmpc_pkg::frame_entry_t             rd_data,
    input  wire logic                          wr_en,
    input  wire logic [dmpc_pkg::FRAME_W-1:0]  wr_addr,
    input  wire dmpc_pkg::frame_entry_t        wr_data
);
    import dmpc_pkg::*;

    frame_entry_t       mem [FRAMES];
    logic [FRAMES-1:0]  valid_reg;
    frame_entry_t       rd_reg;
    frame_entry_t       reset_entry;

    // reset contents: frame i holds page i, clean
    always_comb
    begin
        reset_entry.dirty = 1'b0;
        reset_entry.tag   = {{(PAGE_W-FRAME_W){1'b0}}, rd_addr};
    end

    // written-entry marks
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (wr_en)
        begin
            valid_reg[wr_addr] <= 1'b1;
        end
    end

    // array write
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_reg <= valid_reg[rd_addr] ? mem[rd_addr] : reset_entry;
        end
    end

    assign rd_data = rd_reg;

endmodule

`default_nettype wire

/* hw/rtl/direct_mapped_page_cache_ctrl.sv */
// Direct mapped write-back page cache controller. Each request item carries a byte
// address and a write flag; the page (address bits 21:12) maps to frame
// page mod frames_in_use (0 acts as 1, above 64 acts as 64). A hit gives one access
// item; a miss gives a write-back item if the resident page is dirty, a fetch item,
// then the access item (last_result set). A hit goes from acceptance to the access
// item entering the output register through the modulo unit, the registered read of
// the frame store, the tag compare and entry write and the load of the output
// register; each command item adds a state, and the controller stalls while the
// output register is still full. One request is in flight at a time; the next is
// accepted in the cycle after the access item sits in the output register, even if
// it is not yet taken.
// frames_in_use is written through the cfg channel, which is always ready.
// Depends on dmpc_pkg, dmpc_if, dmpc_mod_unit and dmpc_frame_mem.
`default_nettype none

module direct_mapped_page_cache_ctrl (
    input  wire logic    clk,
    input  wire logic    rst_n,
    dmpc_req_if.sink     req,
    dmpc_rsp_if.source   rsp,
    dmpc_cfg_if.sink     cfg
);
    import dmpc_pkg::*;

    state_t              state_reg, state_next;
    logic [CFG_W-1:0]    frames_reg;
    logic [CFG_W-1:0]    used;
    logic [PAGE_W-1:0]   page_reg;
    logic [OFFSET_W-1:0] offset_reg;
    logic                wr_reg;
    logic                accept;

    logic                mod_done;
    logic [FRAME_W-1:0]  frame;
    logic                mem_rd_en;
    frame_entry_t        rd_entry;
    logic                mem_wr_en;
    frame_entry_t        wr_entry;
    logic                hit;

    logic                rsp_valid_reg;
    kind_t               rsp_kind_reg;
    logic [PAGE_W-1:0]   rsp_page_reg;
    logic [FRAME_W-1:0]  rsp_frame_reg;
    logic [OFFSET_W-1:0] rsp_offset_reg;
    logic                rsp_last_reg;
    logic                slot_free;
    logic                load;
    kind_t               load_kind;
    logic [PAGE_W-1:0]   load_page;
    logic                load_last;

    // configuration register
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frames_reg <= CFG_RESET;
        end
        else if (cfg.valid)
        begin
            frames_reg <= cfg.frames_in_use;
        end
    end

    // clamp the frame count to 1..FRAMES
    always_comb
    begin
        if (frames_reg < CFG_MIN)
        begin
            used = CFG_MIN;
        end
        else if (frames_reg > CFG_MAX)
        begin
            used = CFG_MAX;
        end
        else
        begin
            used = frames_reg;
        end
    end

    assign accept = req.valid && req.ready;

    // latch the request item
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            page_reg   <= req.byte_address[ADDR_W-1:OFFSET_W];
            offset_reg <= req.byte_address[OFFSET_W-1:0];
            wr_reg     <= req.is_write;
        end
    end

    dmpc_mod_unit u_mod (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (accept),
        .dividend  (req.byte_address[ADDR_W-1:OFFSET_W]),
        .divisor   (used),
        .done      (mod_done),
        .remainder (frame)
    );

    dmpc_frame_mem u_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (mem_rd_en),
        .rd_addr (frame),
        .rd_data (rd_entry),
        .wr_en   (mem_wr_en),
        .wr_addr (frame),
        .wr_data (wr_entry)
    );

    assign hit       = (rd_entry.tag == page_reg);
    assign slot_free = !rsp_valid_reg || rsp.ready;

    // updated entry: refill takes the write flag, a hit only sets dirty
    always_comb
    begin
        wr_entry.tag   = page_reg;
        wr_entry.dirty = hit ? (rd_entry.dirty | wr_reg) : wr_reg;
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state and control
    always_comb
    begin
        state_next = state_reg;
        req.ready  = 1'b0;
        mem_rd_en  = 1'b0;
        mem_wr_en  = 1'b0;
        load       = 1'b0;
        load_kind  = KIND_ACCESS;
        load_page  = page_reg;
        load_last  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                req.ready = 1'b1;
                if (req.valid)
                begin
                    state_next = ST_MOD;
                end
            end
            ST_MOD:
            begin
                if (mod_done)
                begin
                    mem_rd_en  = 1'b1;
                    state_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP:
            begin
                mem_wr_en = 1'b1;
                if (hit)
                begin
                    state_next = ST_ACC;
                end
                else if (rd_entry.dirty)
                begin
                    state_next = ST_WB;
                end
                else
                begin
                    state_next = ST_FETCH;
                end
            end
            ST_WB:
            begin
                load_kind = KIND_WB;
                load_page = rd_entry.tag;
                if (slot_free)
                begin
                    load       = 1'b1;
                    state_next = ST_FETCH;
                end
            end
            ST_FETCH:
            begin
                load_kind = KIND_FETCH;
                if (slot_free)
                begin
                    load       = 1'b1;
                    state_next = ST_ACC;
                end
            end
            ST_ACC:
            begin
                load_last = 1'b1;
                if (slot_free)
                begin
                    load       = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // output register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (load)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    // output register payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            rsp_kind_reg   <= load_kind;
            rsp_page_reg   <= load_page;
            rsp_frame_reg  <= frame;
            rsp_offset_reg <= load_last ? offset_reg : '0;
            rsp_last_reg   <= load_last;
        end
    end

    assign rsp.valid       = rsp_valid_reg;
    assign rsp.kind        = rsp_kind_reg;
    assign rsp.page_number = rsp_page_reg;
    assign rsp.frame_index = rsp_frame_reg;
    assign rsp.page_offset = rsp_offset_reg;
    assign rsp.last_result = rsp_last_reg;

endmodule

`default_nettype wire

/* tb/tb_top.sv */
`timescale 1ns / 1ps
// self-checking testbench for direct_mapped_page_cache_ctrl: directed and random accesses
// checked item by item against a behavioral copy of the frame tags and dirty marks
// depends on dmpc_pkg, dmpc_if and the controller rtl

module tb_top;
    import dmpc_pkg::*;

    localparam int HALF_PERIOD     = 10;
    localparam int WATCHDOG_LIMIT  = 3000;
    localparam int HOLD_CYCLES     = 300;
    localparam int DRAIN_CYCLES    = 20;
    localparam int ITEMS_PER_PHASE = 43;
    localparam int RANDOM_PHASES   = 6;

    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic              wr;
    } access_t;

    typedef struct packed {
        kind_t               kind;
        logic [PAGE_W-1:0]   page;
        logic [FRAME_W-1:0]  frame;
        logic [OFFSET_W-1:0] offset;
        logic                last;
    } cache_result_t;

    logic clk;
    logic rst_n;

    dmpc_req_if req_ch ();
    dmpc_rsp_if rsp_ch ();
    dmpc_cfg_if cfg_ch ();

    direct_mapped_page_cache_ctrl u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch),
        .cfg   (cfg_ch)
    );

    // behavioral copy of the frame store and the frames_in_use register
    logic [PAGE_W-1:0] tag_of [FRAMES];
    logic              dirty_of [FRAMES];
    logic [CFG_W-1:0]  frames_reg;

    access_t       pending_accesses [$];
    cache_result_t due_results [$];

    int   mismatches = 0;
    int   send_idle_pct = 0;
    int   recv_idle_pct = 0;
    int   stall_asked = 0;
    int   stall_served = 0;
    int   hold_left = 0;
    int   quiet_cycles = 0;
    logic req_fire = 1'b0;

    // clock
    initial
    begin
        clk = 1'b0;
        forever #HALF_PERIOD clk = ~clk;
    end

    // work out the items one access causes and update the frame copy
    function automatic void cache_lookup(logic [ADDR_W-1:0] addr, logic wr);
        int unsigned         used;
        logic [PAGE_W-1:0]   page;
        logic [OFFSET_W-1:0] offset;
        logic [FRAME_W-1:0]  frame;
        used   = (frames_reg == 0) ? 1 : (frames_reg > FRAMES) ? FRAMES : frames_reg;
        page   = addr[ADDR_W-1:OFFSET_W];
        offset = addr[OFFSET_W-1:0];
        frame  = FRAME_W'(page % used);
        if (tag_of[frame] != page)
        begin
            if (dirty_of[frame])
                due_results.push_back(cache_result_t'{KIND_WB, tag_of[frame], frame,
                                                      OFFSET_W'(0), 1'b0});
            due_results.push_back(cache_result_t'{KIND_FETCH, page, frame,
                                                  OFFSET_W'(0), 1'b0});
            tag_of[frame]   = page;
            dirty_of[frame] = wr;
        end
        else if (wr)
        begin
            dirty_of[frame] = 1'b1;
        end
        due_results.push_back(cache_result_t'{KIND_ACCESS, page, frame, offset, 1'b1});
    endfunction

    task automatic check_field(string field, logic [31:0] want_v, logic [31:0] got_v);
        if (got_v !== want_v)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h",
                     $time, field, want_v, got_v);
            mismatches++;
        end
    endtask

    // driver: offer the oldest pending access, hold it until taken
    always @(negedge clk)
    begin
        if (!(req_ch.valid && !req_fire))
        begin
            if (pending_accesses.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                req_ch.valid        <= 1'b1;
                req_ch.byte_address <= pending_accesses[0].addr;
                req_ch.is_write     <= pending_accesses[0].wr;
            end
            else
            begin
                req_ch.valid <= 1'b0;
            end
        end
    end

    // receiver: random stalls plus a long hold-off when asked
    always @(negedge clk)
    begin
        if (stall_asked != stall_served)
        begin
            stall_served = stall_asked;
            hold_left    = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
        end
        else
        begin
            rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // monitor: track config writes, predict on each accepted access, check results
    always @(posedge clk)
    begin
        cache_result_t want;
        req_fire = rst_n && req_ch.valid && req_ch.ready;
        if (rst_n && cfg_ch.valid && cfg_ch.ready)
            frames_reg = cfg_ch.frames_in_use;
        if (req_fire)
        begin
            cache_lookup(req_ch.byte_address, req_ch.is_write);
            void'(pending_accesses.pop_front());
        end
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (due_results.size() == 0)
            begin
                $display("%0t: unexpected item, expected none, actual kind %0d page %0h",
                         $time, rsp_ch.kind, rsp_ch.page_number);
                mismatches++;
            end
            else
            begin
                want = due_results.pop_front();
                check_field("kind", 32'(want.kind), 32'(rsp_ch.kind));
                check_field("page_number", 32'(want.page), 32'(rsp_ch.page_number));
                check_field("frame_index", 32'(want.frame), 32'(rsp_ch.frame_index));
                check_field("page_offset", 32'(want.offset), 32'(rsp_ch.page_offset));
                check_field("last_result", 32'(want.last), 32'(rsp_ch.last_result));
            end
        end
    end

    // watchdog on cycles with no handshake at all
    always @(posedge clk)
    begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)
            || (cfg_ch.valid && cfg_ch.ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    task automatic write_frames(logic [CFG_W-1:0] value);
        @(negedge clk);
        cfg_ch.valid         <= 1'b1;
        cfg_ch.frames_in_use <= value;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic queue_access(int page, int offset, logic wr);
        pending_accesses.push_back(access_t'{{PAGE_W'(page), OFFSET_W'(offset)}, wr});
    endtask

    // mostly a small set of conflicting hot pages, some repeats, some fully random
    task automatic queue_random_accesses(int count, int used);
        logic [PAGE_W-1:0]   hot [8];
        logic [PAGE_W-1:0]   page;
        logic [OFFSET_W-1:0] offset;
        int                  pick;
        page = PAGE_W'($urandom_range(1023));
        for (int i = 0; i < 8; i++)
            hot[i] = (i < 4) ? PAGE_W'($urandom_range(1023))
                             : hot[i - 4] + PAGE_W'(used * $urandom_range(1, 3));
        for (int n = 0; n < count; n++)
        begin
            pick   = $urandom_range(99);
            offset = OFFSET_W'($urandom);
            if (pick < 55)
                page = hot[$urandom_range(7)];
            else if (pick >= 80)
                page = PAGE_W'($urandom);
            pending_accesses.push_back(access_t'{{page, offset}, 1'($urandom_range(1))});
        end
    endtask

    task automatic wait_drained();
        while (pending_accesses.size() != 0 || due_results.size() != 0)
            @(negedge clk);
    endtask

    // stimulus and end of run
    initial
    begin
        int frames_plan [RANDOM_PHASES];
        int used;
        req_ch.valid         = 1'b0;
        req_ch.byte_address  = '0;
        req_ch.is_write      = 1'b0;
        rsp_ch.ready         = 1'b0;
        cfg_ch.valid         = 1'b0;
        cfg_ch.frames_in_use = '0;
        for (int i = 0; i < FRAMES; i++)
        begin
            tag_of[i]   = PAGE_W'(i);
            dirty_of[i] = 1'b0;
        end
        frames_reg = CFG_RESET;
        rst_n      = 1'b0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed part with the reset frame count
        send_idle_pct = 7;
        recv_idle_pct = 50;
        queue_access(0, 0, 1'b0);          // hit on reset tags
        queue_access(0, 'hFFF, 1'b1);      // write hit marks frame dirty
        queue_access(64, 'h123, 1'b0);     // dirty eviction
        queue_access(0, 0, 1'b0);          // clean miss after read refill
        queue_access(1023, 'hFFF, 1'b1);   // top of address space, write refill
        queue_access(63, 0, 1'b0);         // evicts the written refill
        queue_access(5, 'h800, 1'b1);
        queue_access(5, 'h001, 1'b1);
        queue_access(69, 'h7FF, 1'b0);
        queue_access(69, 'h555, 1'b1);
        wait_drained();

        // zero frames acts as one
        write_frames(CFG_W'(0));
        queue_access(1, 'hABC, 1'b0);
        queue_access(1, 'h000, 1'b1);
        queue_access(2, 'hFFF, 1'b0);
        queue_access(0, 0, 1'b1);
        wait_drained();

        // oversized frame count saturates
        write_frames(CFG_W'(127));
        queue_access(64, 'h010, 1'b0);
        queue_access(127, 'h020, 1'b0);
        pending_accesses.push_back(access_t'{22'h2AAAAA, 1'b1});
        pending_accesses.push_back(access_t'{22'h155555, 1'b0});
        wait_drained();

        // random phases over several frame counts and idling patterns
        frames_plan = '{64, 1, 65, 7, 33, 2};
        frames_plan[RANDOM_PHASES - 1] = $urandom_range(2, 63);
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            if (p < 2)
            begin
                send_idle_pct = 7;
                recv_idle_pct = 50;
            end
            else if (p < 4)
            begin
                send_idle_pct = 50;
                recv_idle_pct = 7;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            write_frames(CFG_W'(frames_plan[p]));
            used = (frames_plan[p] > FRAMES) ? FRAMES : frames_plan[p];
            // long receiver hold-off so the request side backs up
            if (p == 1)
                stall_asked++;
            queue_random_accesses(ITEMS_PER_PHASE, used);
            wait_drained();
        end

        repeat (DRAIN_CYCLES) @(negedge clk);
        if (mismatches == 0 && due_results.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
